// File: src/buddy_page_allocator_defines.svh
// Assertion macros for the buddy page allocator.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_DEFINES_SVH

`define BPA_ASSERT_IMP(name, cond, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error(msg);

`define BPA_ASSERT_NXT(name, cond, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error(msg);

`endif

// File: src/bpa_pkg.sv
// Shared constants, codes and types for the buddy page allocator.
// No dependencies.
`default_nettype none
package bpa_pkg;
  localparam int MAX_PAGES   = 4096;
  localparam int PAGE_W      = 12;
  localparam int LINK_W      = 13;
  localparam int ORDER_COUNT = 11;
  localparam int ORD_W       = 4;
  localparam int BASE_W      = 11;
  localparam int CNT_W       = 10;
  localparam int META_W      = 5;

  localparam logic [LINK_W-1:0] NIL = LINK_W'(MAX_PAGES);
  localparam logic [ORD_W-1:0] ORD_MAX = ORD_W'(ORDER_COUNT - 1);

  localparam logic [1:0] REQ_INIT  = 2'd0;
  localparam logic [1:0] REQ_ALLOC = 2'd1;
  localparam logic [1:0] REQ_FREE  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_BAD_ORD = 2'd2;
  localparam logic [1:0] ST_BAD_REQ = 2'd3;

  localparam logic CFG_POOL = 1'b0;

  typedef struct packed {
    logic [PAGE_W-1:0] buddy;
    logic              in_pool;
    logic              aligned;
    logic              fits;
  } bpa_bud_t;
endpackage
`default_nettype wire

// File: src/bpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: src/bpa_buddy.sv
// Shared buddy unit: buddy page, pool bounds, alignment and fit of a chunk.
// Depends on bpa_pkg.
`default_nettype none
module bpa_buddy (
  input  wire logic [bpa_pkg::PAGE_W-1:0] page,
  input  wire logic [bpa_pkg::ORD_W-1:0]  order,
  input  wire logic [bpa_pkg::BASE_W-1:0] base_lo,
  input  wire logic [bpa_pkg::LINK_W-1:0] act_pages,
  output bpa_pkg::bpa_bud_t               res
);
  import bpa_pkg::*;

  logic [BASE_W-1:0] abs_lo;
  logic [BASE_W-1:0] mask;
  logic [LINK_W-1:0] pw;
  logic [LINK_W-1:0] up;
  logic              hi_bit;

  always_comb begin
    abs_lo = base_lo + page[BASE_W-1:0];
    mask   = (BASE_W'(1) << order) - BASE_W'(1);
    pw     = LINK_W'(1) << order;
    up     = LINK_W'(page) + pw;
    hi_bit = (order < ORD_W'(ORDER_COUNT)) ? abs_lo[order] : 1'b0;
    res.aligned = ((abs_lo & mask) == '0);
    res.fits    = ((LINK_W + 1)'(page) + (LINK_W + 1)'(pw)) <= (LINK_W + 1)'(act_pages);
    if (!hi_bit) begin
      res.buddy   = up[PAGE_W-1:0];
      res.in_pool = up < act_pages;
    end else begin
      res.buddy   = PAGE_W'(LINK_W'(page) - pw);
      res.in_pool = LINK_W'(page) >= pw;
    end
  end
endmodule
`default_nettype wire

// File: src/buddy_page_allocator.sv
// Buddy page allocator: request sequencer, free-list heads and page metadata.
// Depends on bpa_pkg, bpa_ram, bpa_buddy and buddy_page_allocator_defines.svh.
//
// Requests arrive as beats on the in_ channel: tuser carries the request kind
// (init, allocate, free), tdata the order and the page. Every request gives
// exactly one result beat on the out_ channel: tuser carries the status,
// tdata the chunk page, chunk order and total free pages.
// The block takes one request at a time; in_tready is high only while idle.
// Allocate searches upward for a non-empty order, splits the chunk down to the
// requested order and marks its pages, the page-marking loop being the longest step.
// Free merges the chunk with each free buddy, then marks its pages and pushes it.
// Init stamps the metadata of every pool page, then frees each page in turn,
// up to a full pool of 4096 pages.
// Bad requests and refused frees go straight to their result.
// Reset clears the free lists and marks the pool as not initialised; the page
// metadata is not cleared and is only meaningful after an init.
// Configuration writes on cfg_ take effect at the next init.
// A finished result waits in the output register while the receiver stalls;
// the block may already take the next request, and holds its next result
// until the register is empty.
`default_nettype none
`include "buddy_page_allocator_defines.svh"
module buddy_page_allocator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // req_order[5:0], page_index[17:6], zero fill
  input  wire logic [1:0]  in_tuser,   // req_type[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata,  // chunk_page[11:0], chunk_order[15:12],
                                       // free_pages[28:16], zero fill
  output logic      [1:0]  out_tuser,  // status[1:0]
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [51:0] cfg_wdata
);
  import bpa_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_INIT_CLR = 4'd1;
  localparam logic [3:0] S_INIT_PG  = 4'd2;
  localparam logic [3:0] S_FR_CHK   = 4'd3;
  localparam logic [3:0] S_FC_BUD   = 4'd4;
  localparam logic [3:0] S_FC_CHK   = 4'd5;
  localparam logic [3:0] S_RM       = 4'd6;
  localparam logic [3:0] S_MARK     = 4'd7;
  localparam logic [3:0] S_PUSH_A   = 4'd8;
  localparam logic [3:0] S_PUSH_B   = 4'd9;
  localparam logic [3:0] S_AL_SRCH  = 4'd10;
  localparam logic [3:0] S_AL_SPLIT = 4'd11;
  localparam logic [3:0] S_DONE     = 4'd12;

  localparam logic [1:0] M_INIT  = 2'd0;
  localparam logic [1:0] M_ALLOC = 2'd1;
  localparam logic [1:0] M_FREE  = 2'd2;

  logic [3:0]        state_r, state_nxt;
  logic [1:0]        mode_r, mode_nxt;
  logic [PAGE_W-1:0] w_r, w_nxt;
  logic [PAGE_W-1:0] a_r, a_nxt;
  logic [PAGE_W-1:0] rm_r, rm_nxt;
  logic [LINK_W-1:0] hs_r, hs_nxt;
  logic [ORD_W-1:0]  o_r, o_nxt;
  logic [ORD_W-1:0]  req_r, req_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [LINK_W-1:0] i_r, i_nxt;
  logic [LINK_W-1:0] act_r, act_nxt;
  logic [BASE_W-1:0] base_lo_r, base_lo_nxt;
  logic [LINK_W-1:0] cfg_pool_r;
  logic [BASE_W-1:0] cfg_base_r;
  logic              ready_r, ready_nxt;
  logic [LINK_W-1:0] free_r, free_nxt;
  logic              mk_taken_r, mk_taken_nxt;
  logic [1:0]        st_r, st_nxt;
  logic [PAGE_W-1:0] cp_r, cp_nxt;
  logic [ORD_W-1:0]  co_r, co_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_st_r, out_st_nxt;
  logic [PAGE_W-1:0] out_cp_r, out_cp_nxt;
  logic [ORD_W-1:0]  out_co_r, out_co_nxt;
  logic [LINK_W-1:0] out_fp_r, out_fp_nxt;
  logic [LINK_W-1:0] head_r [ORDER_COUNT];
  logic [LINK_W-1:0] head_nxt [ORDER_COUNT];

  logic              meta_we;
  logic [PAGE_W-1:0] meta_waddr, meta_raddr;
  logic [META_W-1:0] meta_wdata, meta_rd;
  logic              next_we, prev_we;
  logic [PAGE_W-1:0] next_waddr, prev_waddr, link_raddr;
  logic [LINK_W-1:0] next_wdata, prev_wdata, next_rd, prev_rd;

  logic [ORD_W-1:0]  bud_ord;
  bpa_bud_t          bud;
  logic [LINK_W-1:0] pw;
  logic [LINK_W-1:0] madd;
  logic              accept;
  logic              free_ok;

  bpa_ram #(.WIDTH(META_W), .DEPTH(MAX_PAGES)) u_meta (
    .clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
    .raddr(meta_raddr), .rdata(meta_rd)
  );

  bpa_ram #(.WIDTH(LINK_W), .DEPTH(MAX_PAGES)) u_next (
    .clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
    .raddr(link_raddr), .rdata(next_rd)
  );

  bpa_ram #(.WIDTH(LINK_W), .DEPTH(MAX_PAGES)) u_prev (
    .clk(clk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
    .raddr(link_raddr), .rdata(prev_rd)
  );

  assign bud_ord = (state_r == S_FR_CHK) ? meta_rd[ORD_W-1:0] : o_r;

  bpa_buddy u_buddy (
    .page(w_r), .order(bud_ord), .base_lo(base_lo_r), .act_pages(act_r), .res(bud)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign pw         = LINK_W'(1) << o_r;
  assign madd       = LINK_W'(w_r) + LINK_W'(cnt_r);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_st_r;
  assign out_tdata  = {3'b000, out_fp_r, out_co_r, out_cp_r};
  assign free_ok    = !meta_rd[META_W-1] ? 1'b0 :
                      ((LINK_W'(w_r) < act_r) && (meta_rd[ORD_W-1:0] <= ORD_MAX) &&
                       bud.aligned && bud.fits);

  always_comb begin
    state_nxt    = state_r;
    mode_nxt     = mode_r;
    w_nxt        = w_r;
    a_nxt        = a_r;
    rm_nxt       = rm_r;
    hs_nxt       = hs_r;
    o_nxt        = o_r;
    req_nxt      = req_r;
    cnt_nxt      = cnt_r;
    i_nxt        = i_r;
    act_nxt      = act_r;
    base_lo_nxt  = base_lo_r;
    ready_nxt    = ready_r;
    free_nxt     = free_r;
    mk_taken_nxt = mk_taken_r;
    st_nxt       = st_r;
    cp_nxt       = cp_r;
    co_nxt       = co_r;
    head_nxt     = head_r;
    meta_we      = 1'b0;
    meta_waddr   = madd[PAGE_W-1:0];
    meta_wdata   = {mk_taken_r, o_r};
    meta_raddr   = bud.buddy;
    next_we      = 1'b0;
    next_waddr   = w_r;
    next_wdata   = head_r[o_r];
    prev_we      = 1'b0;
    prev_waddr   = w_r;
    prev_wdata   = NIL;
    link_raddr   = rm_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_st_nxt   = out_st_r;
    out_cp_nxt   = out_cp_r;
    out_co_nxt   = out_co_r;
    out_fp_nxt   = out_fp_r;

    case (state_r)
      S_IDLE: begin
        meta_raddr = in_tdata[17:6];
        if (accept) begin
          st_nxt    = ST_BAD_REQ;
          cp_nxt    = '0;
          co_nxt    = '0;
          state_nxt = S_DONE;
          case (in_tuser)
            REQ_INIT: begin
              act_nxt     = (cfg_pool_r > LINK_W'(MAX_PAGES)) ? LINK_W'(MAX_PAGES) : cfg_pool_r;
              base_lo_nxt = cfg_base_r;
              for (int k = 0; k < ORDER_COUNT; k++) begin
                head_nxt[k] = NIL;
              end
              free_nxt  = '0;
              ready_nxt = 1'b1;
              i_nxt     = '0;
              st_nxt    = ST_OK;
              if (act_nxt != '0) begin
                state_nxt = S_INIT_CLR;
              end
            end
            REQ_ALLOC: begin
              if (!ready_r) begin
                st_nxt = ST_BAD_REQ;
              end else if (in_tdata[5:0] >= 6'(ORDER_COUNT)) begin
                st_nxt = ST_BAD_ORD;
              end else begin
                o_nxt     = in_tdata[ORD_W-1:0];
                req_nxt   = in_tdata[ORD_W-1:0];
                mode_nxt  = M_ALLOC;
                state_nxt = S_AL_SRCH;
              end
            end
            REQ_FREE: begin
              if (ready_r) begin
                w_nxt     = in_tdata[17:6];
                mode_nxt  = M_FREE;
                state_nxt = S_FR_CHK;
              end
            end
            default: begin
              st_nxt = ST_BAD_REQ;
            end
          endcase
        end
      end
      S_INIT_CLR: begin
        meta_we    = 1'b1;
        meta_waddr = i_r[PAGE_W-1:0];
        meta_wdata = {1'b1, ORD_W'(0)};
        if (i_r == act_r - LINK_W'(1)) begin
          i_nxt     = '0;
          state_nxt = S_INIT_PG;
        end else begin
          i_nxt = i_r + LINK_W'(1);
        end
      end
      S_INIT_PG: begin
        w_nxt     = i_r[PAGE_W-1:0];
        o_nxt     = '0;
        mode_nxt  = M_INIT;
        state_nxt = S_FC_BUD;
      end
      S_FR_CHK: begin
        if (free_ok) begin
          o_nxt     = meta_rd[ORD_W-1:0];
          state_nxt = S_FC_BUD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_FC_BUD: begin
        rm_nxt = bud.buddy;
        if ((o_r < ORD_MAX) && bud.in_pool) begin
          state_nxt = S_FC_CHK;
        end else begin
          cnt_nxt      = '0;
          mk_taken_nxt = 1'b0;
          state_nxt    = S_MARK;
        end
      end
      S_FC_CHK: begin
        if (!meta_rd[META_W-1] && (meta_rd[ORD_W-1:0] == o_r)) begin
          state_nxt = S_RM;
        end else begin
          cnt_nxt      = '0;
          mk_taken_nxt = 1'b0;
          state_nxt    = S_MARK;
        end
      end
      S_RM: begin
        if (!prev_rd[LINK_W-1]) begin
          next_we    = 1'b1;
          next_waddr = prev_rd[PAGE_W-1:0];
          next_wdata = next_rd;
        end else begin
          head_nxt[o_r] = next_rd;
        end
        if (!next_rd[LINK_W-1]) begin
          prev_we    = 1'b1;
          prev_waddr = next_rd[PAGE_W-1:0];
          prev_wdata = prev_rd;
        end
        free_nxt = free_r - pw;
        if (mode_r == M_ALLOC) begin
          state_nxt = S_AL_SPLIT;
        end else begin
          if (rm_r < w_r) begin
            w_nxt = rm_r;
          end
          o_nxt     = o_r + ORD_W'(1);
          state_nxt = S_FC_BUD;
        end
      end
      S_MARK: begin
        meta_we = !madd[LINK_W-1];
        cnt_nxt = cnt_r + CNT_W'(1);
        if (LINK_W'(cnt_r) == pw - LINK_W'(1)) begin
          if (mk_taken_r) begin
            st_nxt    = ST_OK;
            cp_nxt    = w_r;
            co_nxt    = o_r;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_PUSH_A;
          end
        end
      end
      S_PUSH_A: begin
        next_we       = 1'b1;
        prev_we       = 1'b1;
        hs_nxt        = head_r[o_r];
        head_nxt[o_r] = LINK_W'(w_r);
        free_nxt      = free_r + pw;
        state_nxt     = S_PUSH_B;
      end
      S_PUSH_B: begin
        if (!hs_r[LINK_W-1]) begin
          prev_we    = 1'b1;
          prev_waddr = hs_r[PAGE_W-1:0];
          prev_wdata = LINK_W'(w_r);
        end
        case (mode_r)
          M_INIT: begin
            if (i_r == act_r - LINK_W'(1)) begin
              st_nxt    = ST_OK;
              cp_nxt    = '0;
              co_nxt    = '0;
              state_nxt = S_DONE;
            end else begin
              i_nxt     = i_r + LINK_W'(1);
              state_nxt = S_INIT_PG;
            end
          end
          M_FREE: begin
            st_nxt    = ST_OK;
            cp_nxt    = w_r;
            co_nxt    = o_r;
            state_nxt = S_DONE;
          end
          default: begin
            state_nxt = S_AL_SPLIT;
          end
        endcase
      end
      S_AL_SRCH: begin
        link_raddr = head_r[o_r][PAGE_W-1:0];
        if (!head_r[o_r][LINK_W-1]) begin
          a_nxt     = head_r[o_r][PAGE_W-1:0];
          rm_nxt    = head_r[o_r][PAGE_W-1:0];
          state_nxt = S_RM;
        end else if (o_r == ORD_MAX) begin
          st_nxt    = ST_NO_FREE;
          state_nxt = S_DONE;
        end else begin
          o_nxt = o_r + ORD_W'(1);
        end
      end
      S_AL_SPLIT: begin
        cnt_nxt = '0;
        if (o_r > req_r) begin
          o_nxt        = o_r - ORD_W'(1);
          w_nxt        = a_r + PAGE_W'(pw >> 1);
          mk_taken_nxt = 1'b0;
        end else begin
          w_nxt        = a_r;
          mk_taken_nxt = 1'b1;
        end
        state_nxt = S_MARK;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = st_r;
          out_cp_nxt    = cp_r;
          out_co_nxt    = co_r;
          out_fp_nxt    = free_nxt;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
      free_r      <= '0;
      cfg_pool_r  <= LINK_W'(MAX_PAGES);
      cfg_base_r  <= '0;
      act_r       <= '0;
      base_lo_r   <= '0;
      for (int k = 0; k < ORDER_COUNT; k++) begin
        head_r[k] <= NIL;
      end
    end else begin
      state_r     <= state_nxt;
      ready_r     <= ready_nxt;
      out_valid_r <= out_valid_nxt;
      free_r      <= free_nxt;
      act_r       <= act_nxt;
      base_lo_r   <= base_lo_nxt;
      head_r      <= head_nxt;
      if (cfg_we) begin
        if (cfg_addr == CFG_POOL) begin
          cfg_pool_r <= cfg_wdata[LINK_W-1:0];
        end else begin
          cfg_base_r <= cfg_wdata[BASE_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    w_r        <= w_nxt;
    a_r        <= a_nxt;
    rm_r       <= rm_nxt;
    hs_r       <= hs_nxt;
    o_r        <= o_nxt;
    req_r      <= req_nxt;
    cnt_r      <= cnt_nxt;
    i_r        <= i_nxt;
    mk_taken_r <= mk_taken_nxt;
    st_r       <= st_nxt;
    cp_r       <= cp_nxt;
    co_r       <= co_nxt;
    out_st_r   <= out_st_nxt;
    out_cp_r   <= out_cp_nxt;
    out_co_r   <= out_co_nxt;
    out_fp_r   <= out_fp_nxt;
  end

  `BPA_ASSERT_NXT(a_accept_busy, accept, state_r != S_IDLE, "request accepted while idle stayed idle")
  `BPA_ASSERT_IMP(a_free_bound, 1'b1, free_r <= LINK_W'(MAX_PAGES), "free page total above pool size")
  `BPA_ASSERT_IMP(a_mark_range, state_r == S_MARK, LINK_W'(cnt_r) < pw, "mark counter beyond chunk")
endmodule
`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for buddy_page_allocator: directed table, then random phases.
// Checks each result beat against typed rows or a free-list predictor; needs bpa_pkg.
`timescale 1ns / 100ps
module testbench;
  import bpa_pkg::*;

  localparam logic [1:0] REQ_RSVD = 2'd3;

  typedef struct {
    logic [1:0]  status;
    logic [11:0] page;
    logic [3:0]  order;
    logic [12:0] free;
  } alloc_result_t;

  typedef struct {
    logic [1:0]    kind;
    logic [5:0]    order;
    logic [11:0]   page;
    bit            typed;
    alloc_result_t res;
  } req_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [51:0] cfg_wdata = '0;

  buddy_page_allocator i_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow of the allocator state.
  int              sh_order[MAX_PAGES];
  bit              sh_taken[MAX_PAGES];
  int              sh_next[MAX_PAGES];
  int              sh_prev[MAX_PAGES];
  int              sh_head[ORDER_COUNT];
  int              sh_count[ORDER_COUNT];
  bit              sh_ready;
  int              reg_pool;
  longint unsigned reg_base;
  int              act_pages;
  longint unsigned act_base;

  alloc_result_t   expected_results[$];
  int              held_chunks[$];
  int              errors;
  int              results_seen;
  int              burst_left;

  function automatic void list_push(int o, int p);
    sh_prev[p] = MAX_PAGES;
    sh_next[p] = sh_head[o];
    if (sh_head[o] < MAX_PAGES) sh_prev[sh_head[o]] = p;
    sh_head[o] = p;
    sh_count[o]++;
  endfunction

  function automatic void list_unlink(int o, int p);
    if (sh_prev[p] < MAX_PAGES) sh_next[sh_prev[p]] = sh_next[p];
    else sh_head[o] = sh_next[p];
    if (sh_next[p] < MAX_PAGES) sh_prev[sh_next[p]] = sh_prev[p];
    sh_count[o]--;
  endfunction

  function automatic void stamp_chunk(int p, int o, bit taken);
    for (int i = 0; i < (1 << o); i++) begin
      if (p + i < MAX_PAGES) begin
        sh_order[p + i] = o;
        sh_taken[p + i] = taken;
      end
    end
  endfunction

  function automatic int free_page_total();
    int s;
    s = 0;
    for (int o = 0; o < ORDER_COUNT; o++) s += sh_count[o] << o;
    return s;
  endfunction

  function automatic int release_and_merge(int p, output int ord);
    int              o;
    int              b;
    longint unsigned b_abs;
    o = sh_order[p];
    stamp_chunk(p, o, 0);
    while (o + 1 < ORDER_COUNT) begin
      b_abs = (act_base + longint'(p)) ^ (64'd1 << o);
      if (b_abs < act_base || b_abs >= act_base + longint'(act_pages)) break;
      b = int'(b_abs - act_base);
      if (sh_taken[b] || sh_order[b] != o) break;
      list_unlink(o, b);
      if (b < p) p = b;
      o++;
      stamp_chunk(p, o, 0);
    end
    list_push(o, p);
    ord = o;
    return p;
  endfunction

  function automatic alloc_result_t predict_request(logic [1:0] kind, int req, int idx);
    alloc_result_t   r;
    int              o;
    int              p;
    int              d;
    longint unsigned mask;
    r.status = ST_BAD_REQ;
    r.page = '0;
    r.order = '0;
    if (kind == REQ_INIT) begin
      act_pages = reg_pool > MAX_PAGES ? MAX_PAGES : reg_pool;
      act_base = reg_base;
      for (o = 0; o < ORDER_COUNT; o++) begin
        sh_head[o] = MAX_PAGES;
        sh_count[o] = 0;
      end
      for (int i = 0; i < act_pages; i++) begin
        sh_order[i] = 0;
        sh_taken[i] = 1;
      end
      for (int i = 0; i < act_pages; i++) void'(release_and_merge(i, d));
      sh_ready = 1;
      r.status = ST_OK;
      held_chunks.delete();
    end else if (kind == REQ_ALLOC) begin
      if (!sh_ready) r.status = ST_BAD_REQ;
      else if (req >= ORDER_COUNT) r.status = ST_BAD_ORD;
      else begin
        o = req;
        while (o < ORDER_COUNT && sh_count[o] == 0) o++;
        if (o >= ORDER_COUNT) r.status = ST_NO_FREE;
        else begin
          p = sh_head[o];
          list_unlink(o, p);
          while (o > req) begin
            o--;
            stamp_chunk(p + (1 << o), o, 0);
            list_push(o, p + (1 << o));
          end
          stamp_chunk(p, req, 1);
          r.status = ST_OK;
          r.page = 12'(p);
          r.order = 4'(req);
          held_chunks.push_back(p);
        end
      end
    end else if (kind == REQ_FREE) begin
      if (sh_ready && idx < act_pages && sh_taken[idx]) begin
        o = sh_order[idx];
        mask = (64'd1 << o) - 1;
        if (o < ORDER_COUNT && ((act_base + longint'(idx)) & mask) == 0 &&
            idx + (1 << o) <= act_pages) begin
          r.page = 12'(release_and_merge(idx, d));
          r.order = 4'(d);
          r.status = ST_OK;
          foreach (held_chunks[k]) begin
            if (held_chunks[k] == idx) begin
              held_chunks.delete(k);
              break;
            end
          end
        end
      end
    end
    r.free = 13'(free_page_total());
    return r;
  endfunction

  task automatic send_request(req_row_t row);
    alloc_result_t r;
    int            gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= row.kind;
    in_tdata <= {6'd0, row.page, row.order};
    do @(posedge clk); while (!in_tready);
    r = predict_request(row.kind, int'(row.order), int'(row.page));
    expected_results.push_back(row.typed ? row.res : r);
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 12);
      gap = $urandom_range(1, 10);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [51:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    if (idx == CFG_POOL) reg_pool = int'(value[12:0]);
    else reg_base = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic req_row_t row(logic [1:0] k, int o, int p, bit t = 0,
                                   int st = 0, int cp = 0, int co = 0, int fp = 0);
    req_row_t x;
    x.kind = k;
    x.order = 6'(o);
    x.page = 12'(p);
    x.typed = t;
    x.res.status = 2'(st);
    x.res.page = 12'(cp);
    x.res.order = 4'(co);
    x.res.free = 13'(fp);
    return x;
  endfunction

  function automatic req_row_t random_row();
    int r;
    int o;
    r = $urandom_range(0, 99);
    if (r < 50 || (r < 85 && held_chunks.size() == 0)) begin
      o = $urandom_range(0, 99);
      o = o < 75 ? $urandom_range(0, 3) : o < 95 ? $urandom_range(4, 10)
                                                 : $urandom_range(11, 63);
      return row(REQ_ALLOC, o, $urandom_range(0, 4095));
    end
    if (r < 85)
      return row(REQ_FREE, $urandom_range(0, 63),
                 held_chunks[$urandom_range(0, held_chunks.size() - 1)]);
    if (r < 94) return row(REQ_FREE, $urandom_range(0, 63), $urandom_range(0, 4095));
    if (r < 98) return row(REQ_RSVD, $urandom_range(0, 63), $urandom_range(0, 4095));
    return row(REQ_INIT, $urandom_range(0, 63), $urandom_range(0, 4095));
  endfunction

  // Receiver: changing stall pattern plus one long hold-off.
  int  ready_mode;
  int  mode_cycles;
  int  hold_cycles;
  bit  hold_done;
  always @(negedge clk) begin
    if (mode_cycles == 0) begin
      ready_mode <= $urandom_range(0, 2);
      mode_cycles <= $urandom_range(20, 120);
    end else begin
      mode_cycles <= mode_cycles - 1;
    end
    if (!hold_done && results_seen == 60 && hold_cycles == 0) begin
      hold_cycles <= 400;
      hold_done <= 1'b1;
      out_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      case (ready_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 1) == 1);
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    alloc_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual st=%0d tdata=%h", $time,
                 out_tuser, out_tdata);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_tuser !== e.status || out_tdata[11:0] !== e.page ||
            out_tdata[15:12] !== e.order || out_tdata[28:16] !== e.free ||
            out_tdata[31:29] !== 3'd0) begin
          $display("%0t: mismatch exp st=%0d page=%0d ord=%0d free=%0d", $time,
                   e.status, e.page, e.order, e.free);
          $display("%0t:          act st=%0d page=%0d ord=%0d free=%0d", $time,
                   out_tuser, out_tdata[11:0], out_tdata[15:12], out_tdata[28:16]);
          errors++;
        end
      end
    end
  end

  initial begin
    #40ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    req_row_t table_rows[$];
    int       pools[$];
    errors = 0;
    results_seen = 0;
    burst_left = 0;
    mode_cycles = 0;
    ready_mode = 0;
    hold_cycles = 0;
    hold_done = 0;
    sh_ready = 0;
    reg_pool = 4096;
    reg_base = 0;
    act_pages = 0;
    act_base = 0;
    for (int o = 0; o < ORDER_COUNT; o++) begin
      sh_head[o] = MAX_PAGES;
      sh_count[o] = 0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    table_rows.push_back(row(REQ_ALLOC, 0, 0, 1, ST_BAD_REQ, 0, 0, 0));
    table_rows.push_back(row(REQ_FREE, 0, 0, 1, ST_BAD_REQ, 0, 0, 0));
    table_rows.push_back(row(REQ_RSVD, 63, 4095, 1, ST_BAD_REQ, 0, 0, 0));
    table_rows.push_back(row(REQ_INIT, 0, 0, 1, ST_OK, 0, 0, 4096));
    table_rows.push_back(row(REQ_ALLOC, 11, 0, 1, ST_BAD_ORD, 0, 0, 4096));
    table_rows.push_back(row(REQ_ALLOC, 63, 4095, 1, ST_BAD_ORD, 0, 0, 4096));
    table_rows.push_back(row(REQ_FREE, 0, 4095, 1, ST_BAD_REQ, 0, 0, 4096));
    table_rows.push_back(row(REQ_ALLOC, 10, 0, 1, ST_OK, 3072, 10, 3072));
    table_rows.push_back(row(REQ_FREE, 0, 4095, 1, ST_BAD_REQ, 0, 0, 3072));
    table_rows.push_back(row(REQ_ALLOC, 0, 0));
    table_rows.push_back(row(REQ_ALLOC, 5, 0));
    table_rows.push_back(row(REQ_FREE, 0, 2049));
    table_rows.push_back(row(REQ_FREE, 0, 2048));
    table_rows.push_back(row(REQ_FREE, 0, 3072));
    table_rows.push_back(row(REQ_ALLOC, 10, 0));
    table_rows.push_back(row(REQ_ALLOC, 10, 0));
    table_rows.push_back(row(REQ_ALLOC, 10, 0));
    table_rows.push_back(row(REQ_ALLOC, 10, 0));
    table_rows.push_back(row(REQ_ALLOC, 10, 0));
    table_rows.push_back(row(REQ_ALLOC, 0, 0));
    table_rows.push_back(row(REQ_FREE, 0, 1024));
    foreach (table_rows[i]) send_request(table_rows[i]);
    drain_results();

    pools = '{1, 0, 8191, 37, 256, 200, 97, 3};
    foreach (pools[ph]) begin
      write_reg(CFG_POOL, 52'(pools[ph]));
      case (ph)
        0: write_reg(!CFG_POOL, {52{1'b1}});
        1: write_reg(!CFG_POOL, 52'd5);
        2: write_reg(!CFG_POOL, 52'd0);
        default: write_reg(!CFG_POOL, 52'({$urandom, $urandom}));
      endcase
      send_request(row(REQ_INIT, 0, 0));
      repeat (ph == 2 ? 20 : 85) send_request(random_row());
      drain_results();
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// File: sim.f
+incdir+src
src/bpa_pkg.sv
src/bpa_ram.sv
src/bpa_buddy.sv
src/buddy_page_allocator.sv
tb/testbench.sv
